@@ design/pat_pkg.sv @@
// Shared types and constants of the peer address table.
package pat_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_MAX_ENTRIES = 1'b0;

    // Field widths
    localparam int ADDR_HALF_W = 64;
    localparam int PORT_W      = 16;
    localparam int FLOW_W      = 32;
    localparam int SCOPE_W     = 32;
    localparam int LEN_W       = 16;
    localparam int CONN_W      = 16;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 5;
    localparam int OCC_W       = 6;
    localparam int MAX_W       = 6;
    localparam int KEY_W       = 2 * ADDR_HALF_W + PORT_W + FLOW_W + SCOPE_W;

    localparam logic [MAX_W-1:0] MAX_ENTRIES_RST = 6'd32;
    localparam int DEFAULT_TABLE_DEPTH = 32;

    typedef enum logic [STATUS_W-1:0] {
        STS_HIT         = 3'd0,
        STS_INSERTED    = 3'd1,
        STS_FULL        = 3'd2,
        STS_ZERO_LEN    = 3'd3,
        STS_REMOVED     = 3'd4,
        STS_REMOVE_MISS = 3'd5
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic start;
        logic scan_step;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

@@ design/pat_ctrl.sv @@
// Sequencer of the peer address table: accept, scan, drain, decide.
module pat_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pat_pkg::t_dp_stat i_stat,
    output pat_pkg::t_dp_cmd  o_cmd
);
    import pat_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_DECIDE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state         = r_state;
        o_cmd.start     = 1'b0;
        o_cmd.scan_step = 1'b0;
        o_cmd.commit    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                // hold until the result register can take the outcome
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ design/pat_dp.sv @@
// Datapath of the peer address table: key memory, scan compare, update, result register.
module pat_dp #(
    parameter int TABLE_DEPTH = pat_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pat_pkg::t_dp_cmd                i_cmd,
    output pat_pkg::t_dp_stat               o_stat,
    input  logic [pat_pkg::MAX_W-1:0]       i_max_entries,
    input  logic                            i_action,
    input  logic [pat_pkg::ADDR_HALF_W-1:0] i_addr_hi,
    input  logic [pat_pkg::ADDR_HALF_W-1:0] i_addr_lo,
    input  logic [pat_pkg::PORT_W-1:0]      i_peer_port,
    input  logic [pat_pkg::FLOW_W-1:0]      i_flow_info,
    input  logic [pat_pkg::SCOPE_W-1:0]     i_scope_id,
    input  logic [pat_pkg::LEN_W-1:0]       i_payload_length,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [pat_pkg::STATUS_W-1:0]    o_status,
    output logic [pat_pkg::SLOT_W-1:0]      o_slot,
    output logic [pat_pkg::CONN_W-1:0]      o_conn_id,
    output logic [pat_pkg::OCC_W-1:0]       o_occupancy
);
    import pat_pkg::*;

    localparam int IW     = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > MAX_W) ? CNT_W : MAX_W;
    localparam int DATA_W = KEY_W + CONN_W;

    // key memory, one read per scan cycle
    logic [DATA_W-1:0]      r_mem [TABLE_DEPTH];
    logic [DATA_W-1:0]      r_rd_data;

    logic [TABLE_DEPTH-1:0] r_valid;
    logic [CNT_W-1:0]       r_count;
    logic [CONN_W-1:0]      r_next_conn;

    logic [KEY_W-1:0]       r_key;
    logic                   r_action;
    logic                   r_len_zero;

    logic [IW-1:0]          r_rd_idx;
    logic                   r_cmp_vld;
    logic [IW-1:0]          r_cmp_idx;

    logic                   r_found;
    logic [IW-1:0]          r_found_idx;
    logic [CONN_W-1:0]      r_found_conn;
    logic                   r_free_found;
    logic [IW-1:0]          r_free_idx;

    logic                   r_out_valid;
    t_status                r_out_status;
    logic [SLOT_W-1:0]      r_out_slot;
    logic [CONN_W-1:0]      r_out_conn;
    logic [OCC_W-1:0]       r_out_occ;

    logic                   cmp_entry_valid;
    logic                   cmp_hit;
    logic                   cmp_free;

    t_status                n_status;
    logic [IW-1:0]          n_idx;
    logic [CONN_W-1:0]      n_conn;
    logic [CNT_W-1:0]       n_count;
    logic                   dec_insert;
    logic                   dec_remove;
    logic                   slot_valid;
    logic [CMP_W-1:0]       cnt_ext;
    logic [CMP_W-1:0]       max_ext;
    logic [CMP_W-1:0]       limit;
    logic                   is_full;

    assign o_stat.scan_last = (r_rd_idx == IW'(TABLE_DEPTH - 1));
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // compare stage, one slot per cycle behind the memory read
    assign cmp_entry_valid = r_valid[r_cmp_idx];
    assign cmp_hit  = r_cmp_vld && cmp_entry_valid &&
                      (r_rd_data[DATA_W-1 -: KEY_W] == r_key);
    assign cmp_free = r_cmp_vld && !cmp_entry_valid;

    // decide the outcome once the scan has drained
    assign cnt_ext = CMP_W'(r_count);
    assign max_ext = CMP_W'(i_max_entries);
    assign limit   = (max_ext > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH) : max_ext;
    assign is_full = !r_free_found || ((r_count != '0) && (cnt_ext >= limit));

    always_comb begin
        n_status   = STS_HIT;
        n_idx      = r_found_idx;
        n_conn     = r_found_conn;
        n_count    = r_count;
        dec_insert = 1'b0;
        dec_remove = 1'b0;
        slot_valid = 1'b1;
        if (r_action) begin
            if (r_found) begin
                n_status   = STS_REMOVED;
                dec_remove = 1'b1;
                n_count    = r_count - CNT_W'(1);
            end else begin
                n_status   = STS_REMOVE_MISS;
                slot_valid = 1'b0;
            end
        end else if (r_found) begin
            n_status = STS_HIT;
        end else if (is_full) begin
            n_status   = STS_FULL;
            slot_valid = 1'b0;
        end else if (r_len_zero) begin
            n_status   = STS_ZERO_LEN;
            slot_valid = 1'b0;
        end else begin
            n_status   = STS_INSERTED;
            dec_insert = 1'b1;
            n_idx      = r_free_idx;
            n_conn     = r_next_conn;
            n_count    = r_count + CNT_W'(1);
        end
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
        if (i_cmd.commit && dec_insert) begin
            r_mem[r_free_idx] <= {r_key, r_next_conn};
        end
    end

    // request capture and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key      <= {i_addr_hi, i_addr_lo, i_peer_port, i_flow_info, i_scope_id};
            r_action   <= i_action;
            r_len_zero <= (i_payload_length == '0);
        end
        if (cmp_hit && !r_found) begin
            r_found_idx  <= r_cmp_idx;
            r_found_conn <= r_rd_data[CONN_W-1:0];
        end
        if (cmp_free && !r_free_found) begin
            r_free_idx <= r_cmp_idx;
        end
        if (i_cmd.scan_step) begin
            r_cmp_idx <= r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx     <= '0;
            r_cmp_vld    <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_step;
            if (i_cmd.start) begin
                r_rd_idx     <= '0;
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
            end else begin
                if (i_cmd.scan_step) begin
                    r_rd_idx <= r_rd_idx + IW'(1);
                end
                if (cmp_hit) begin
                    r_found <= 1'b1;
                end
                if (cmp_free) begin
                    r_free_found <= 1'b1;
                end
            end
        end
    end

    // table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_count     <= '0;
            r_next_conn <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
            if (dec_insert) begin
                r_valid[r_free_idx] <= 1'b1;
                r_next_conn         <= r_next_conn + CONN_W'(1);
            end
            if (dec_remove) begin
                r_valid[r_found_idx] <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status <= n_status;
            r_out_slot   <= slot_valid ? SLOT_W'(n_idx) : '0;
            r_out_conn   <= slot_valid ? n_conn : '0;
            r_out_occ    <= OCC_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_slot      = r_out_slot;
    assign o_conn_id   = r_out_conn;
    assign o_occupancy = r_out_occ;

endmodule

@@ design/peer_address_table.sv @@
// Top level of the peer address table: configuration register, sequencer and datapath.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------------
//  request  | i_in_valid / o_in_ready    | action, addr_hi/lo, port, flow, scope, length
//  result   | o_out_valid / i_out_ready  | status, slot, conn_id, occupancy
//  config   | psel, penable, pwrite      | paddr, pwdata, prdata (max_entries at 0x0)
//
// A request is captured at its accepting edge; its scan then reads the key memory one slot
// per cycle through its single read port, the compare stage drains, and the decide step
// writes the result once the result register is free. The block takes the next request
// only after that write, so it never holds more than one request in flight.
// Reset (synchronous, active low) clears the valid bits, counters and max_entries to 32;
// the key memory holds no reset value and needs no clearing pass.
// A waiting result does not block acceptance of the next request; a result that is
// decided while the previous one still waits holds in the decide step.
module peer_address_table #(
    parameter int TABLE_DEPTH = pat_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pat_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [pat_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [pat_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_action,
    input  logic [pat_pkg::ADDR_HALF_W-1:0] i_addr_hi,
    input  logic [pat_pkg::ADDR_HALF_W-1:0] i_addr_lo,
    input  logic [pat_pkg::PORT_W-1:0]      i_peer_port,
    input  logic [pat_pkg::FLOW_W-1:0]      i_flow_info,
    input  logic [pat_pkg::SCOPE_W-1:0]     i_scope_id,
    input  logic [pat_pkg::LEN_W-1:0]       i_payload_length,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [pat_pkg::STATUS_W-1:0]    o_status,
    output logic [pat_pkg::SLOT_W-1:0]      o_slot,
    output logic [pat_pkg::CONN_W-1:0]      o_conn_id,
    output logic [pat_pkg::OCC_W-1:0]       o_occupancy
);
    import pat_pkg::*;

    logic [MAX_W-1:0] r_max_entries;
    logic             reg_sel;
    logic             cfg_wr;
    t_dp_cmd          dp_cmd;
    t_dp_stat         dp_stat;

    // Word address selects the register; byte offset bits are ignored.
    assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_MAX_ENTRIES);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;

    // Hold max_entries; only the low six bits of the write data count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= MAX_ENTRIES_RST;
        end else if (cfg_wr) begin
            r_max_entries <= pwdata[MAX_W-1:0];
        end
    end

    // Read back the register, zero elsewhere.
    assign prdata = reg_sel ? CFG_DATA_W'(r_max_entries) : '0;

    // Sequence each request: capture, scan every slot, drain, decide.
    pat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Hold keys, compare, update the table and present the result.
    pat_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_max_entries    (r_max_entries),
        .i_action         (i_action),
        .i_addr_hi        (i_addr_hi),
        .i_addr_lo        (i_addr_lo),
        .i_peer_port      (i_peer_port),
        .i_flow_info      (i_flow_info),
        .i_scope_id       (i_scope_id),
        .i_payload_length (i_payload_length),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_slot           (o_slot),
        .o_conn_id        (o_conn_id),
        .o_occupancy      (o_occupancy)
    );

endmodule
